@@ rtl/pcan_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcan_pkg: shared types and constants of the playback controller
// Beat layouts for the event and result channels, action and command codes,
// register map and the tick counter helpers.
// ----------------------------------------------------------------------------
package pcan_pkg;

    // Width of the two saturating tick counters (8 to 32)
    localparam int TICK_W  = 16;
    // Width of the tick threshold registers
    localparam int THR_W   = 16;
    // Common width for comparing a counter against a threshold
    localparam int CMP_W   = (TICK_W > THR_W) ? TICK_W : THR_W;

    localparam logic [TICK_W-1:0] CNT_MAX = {TICK_W{1'b1}};

    // Hard ceiling of the volume scale
    localparam logic [4:0] VOL_LIMIT = 5'd30;

    // Reset values
    localparam logic [7:0]       RST_TRACK_TOTAL  = 8'd5;
    localparam logic [THR_W-1:0] RST_STABLE_TICKS = THR_W'(20);
    localparam logic [THR_W-1:0] RST_IGNORE_TICKS = THR_W'(500);
    localparam logic [4:0]       RST_VOLUME_MAX   = 5'd30;
    localparam logic [4:0]       RST_VOLUME       = 5'd20;
    localparam logic [7:0]       RST_TRACK        = 8'd1;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_TRACK_TOTAL  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STABLE_TICKS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IGNORE_TICKS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_VOLUME_MAX   = 3'd3;

    // Event codes
    localparam logic [2:0] ACT_TICK     = 3'd0;
    localparam logic [2:0] ACT_PLAY     = 3'd1;
    localparam logic [2:0] ACT_PREV     = 3'd2;
    localparam logic [2:0] ACT_NEXT     = 3'd3;
    localparam logic [2:0] ACT_SOURCE   = 3'd4;
    localparam logic [2:0] ACT_VOL_UP   = 3'd5;
    localparam logic [2:0] ACT_VOL_DOWN = 3'd6;

    // Player command codes
    localparam logic [2:0] CMD_NONE  = 3'd0;
    localparam logic [2:0] CMD_PLAY  = 3'd1;
    localparam logic [2:0] CMD_PAUSE = 3'd2;
    localparam logic [2:0] CMD_NEXT  = 3'd3;
    localparam logic [2:0] CMD_PREV  = 3'd4;
    localparam logic [2:0] CMD_VOL   = 3'd5;

    typedef struct packed {
        logic [2:0] action;
        logic       busy_idle;
    } t_in_item;

    typedef struct packed {
        logic [2:0] player_cmd;
        logic [4:0] volume_level;
        logic [7:0] track_number;
        logic       is_playing;
        logic       source_bluetooth;
    } t_out_item;

    // Advance a tick counter, holding at full scale
    function automatic logic [TICK_W-1:0] sat_inc(input logic [TICK_W-1:0] v);
        return (v == CNT_MAX) ? v : v + TICK_W'(1);
    endfunction

    // Limit a threshold to the counter's full scale
    function automatic logic [CMP_W-1:0] clamp_thr(input logic [THR_W-1:0] t);
        logic [CMP_W-1:0] ext;
        ext = CMP_W'(t);
        return (ext > CMP_W'(CNT_MAX)) ? CMP_W'(CNT_MAX) : ext;
    endfunction

endpackage

@@ rtl/playback_controller_auto_next_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// playback_controller_auto_next_core: player control with auto next track
// Takes tick and button events, keeps play, track, volume and source state,
// debounces the player busy pin and issues one result per event.
// ----------------------------------------------------------------------------
// Usage
//   Event channel (i_in_valid / o_in_ready / i_in): one beat per event, either
//   a millisecond tick carrying the sampled busy pin or a button action.
//   Result channel (o_out_valid / i_out_ready / o_out): exactly one beat per
//   event, in order, carrying the command to the player and the state after it.
//   Config channel (i_cfg_valid / o_cfg_ready / i_cfg_index / i_cfg_data):
//   always ready; write only while no event is in flight.
//   Each result is registered in the result or skid register. Throughput:
//   one event per cycle while o_in_ready is high; all state is updated in
//   the accepting cycle, so back-to-back events see each other's effects.
//   Stall: a two-beat output buffer (result register plus skid register)
//   lets one more event in while a result waits; with both full o_in_ready
//   drops until the receiver takes a beat.
//   Reset (synchronous, active low): state and registers return to their
//   defaults and both output slots empty.
// ----------------------------------------------------------------------------
module playback_controller_auto_next_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  pcan_pkg::t_in_item                i_in,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output pcan_pkg::t_out_item               o_out,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [pcan_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [pcan_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import pcan_pkg::*;

    // Configuration registers
    logic [7:0]        r_track_total;
    logic [THR_W-1:0]  r_stable_ticks;
    logic [THR_W-1:0]  r_ignore_ticks;
    logic [4:0]        r_volume_max;

    // Controller state
    logic [4:0]        r_volume,        n_volume;
    logic [7:0]        r_track,         n_track;
    logic              r_playing,       n_playing;
    logic              r_source,        n_source;
    logic              r_busy_stable,   n_busy_stable;
    logic              r_busy_sample,   n_busy_sample;
    logic [TICK_W-1:0] r_since_cmd,     n_since_cmd;
    logic [TICK_W-1:0] r_since_chg,     n_since_chg;
    logic [2:0]        n_cmd;

    // Output buffer
    logic              r_out_valid, r_skid_valid;
    t_out_item         r_out, r_skid, n_item;

    logic              in_beat, out_beat;
    logic [4:0]        vmax;
    logic [7:0]        eff_total, next_track;
    logic [TICK_W-1:0] cmd_inc, chg_inc;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign in_beat     = i_in_valid && o_in_ready;
    assign out_beat    = r_out_valid && i_out_ready;

    // Effective limits and the wrapped next track
    assign vmax       = (r_volume_max > VOL_LIMIT) ? VOL_LIMIT : r_volume_max;
    assign eff_total  = (r_track_total == 8'd0) ? 8'd1 : r_track_total;
    assign next_track = (r_track < eff_total) ? r_track + 8'd1 : 8'd1;
    assign cmd_inc    = sat_inc(r_since_cmd);
    assign chg_inc    = sat_inc(r_since_chg);

    // Work out the next state and the command for the event on the port
    always_comb begin
        n_volume      = r_volume;
        n_track       = r_track;
        n_playing     = r_playing;
        n_source      = r_source;
        n_busy_stable = r_busy_stable;
        n_busy_sample = r_busy_sample;
        n_since_cmd   = r_since_cmd;
        n_since_chg   = r_since_chg;
        n_cmd         = CMD_NONE;

        if (i_in.action == ACT_TICK) begin
            n_since_cmd = cmd_inc;
            n_since_chg = chg_inc;
            if (!r_source && (CMP_W'(cmd_inc) >= clamp_thr(r_ignore_ticks))) begin
                if (i_in.busy_idle != r_busy_sample) begin
                    // restart the stability window on a fresh level
                    n_busy_sample = i_in.busy_idle;
                    n_since_chg   = '0;
                end else if (CMP_W'(chg_inc) >= clamp_thr(r_stable_ticks) &&
                             r_busy_stable != r_busy_sample) begin
                    n_busy_stable = r_busy_sample;
                    // playback ended by itself: move on to the next track
                    if (!r_busy_stable && r_playing) begin
                        n_track     = next_track;
                        n_since_cmd = '0;
                        n_cmd       = CMD_NEXT;
                    end
                end
            end
        end else if (i_in.action == ACT_SOURCE) begin
            if (!r_source) begin
                if (r_playing) begin
                    n_cmd       = CMD_PAUSE;
                    n_playing   = 1'b0;
                    n_since_cmd = '0;
                end
                n_source = 1'b1;
            end else begin
                n_source = 1'b0;
            end
        end else if (!r_source) begin
            unique case (i_in.action)
                ACT_PLAY: begin
                    n_cmd       = r_playing ? CMD_PAUSE : CMD_PLAY;
                    n_playing   = !r_playing;
                    n_since_cmd = '0;
                end
                ACT_PREV: begin
                    n_track     = (r_track > 8'd1) ? r_track - 8'd1 : eff_total;
                    n_playing   = 1'b1;
                    n_cmd       = CMD_PREV;
                    n_since_cmd = '0;
                end
                ACT_NEXT: begin
                    n_track     = next_track;
                    n_playing   = 1'b1;
                    n_cmd       = CMD_NEXT;
                    n_since_cmd = '0;
                end
                ACT_VOL_UP: begin
                    if (r_volume < vmax) begin
                        n_volume = r_volume + 5'd1;
                        n_cmd    = CMD_VOL;
                    end
                end
                ACT_VOL_DOWN: begin
                    if (r_volume != 5'd0) begin
                        n_volume = r_volume - 5'd1;
                        n_cmd    = CMD_VOL;
                    end
                end
                default: begin
                end
            endcase
        end

        n_item.player_cmd       = n_cmd;
        n_item.volume_level     = n_volume;
        n_item.track_number     = n_track;
        n_item.is_playing       = n_playing;
        n_item.source_bluetooth = n_source;
    end

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_track_total  <= RST_TRACK_TOTAL;
            r_stable_ticks <= RST_STABLE_TICKS;
            r_ignore_ticks <= RST_IGNORE_TICKS;
            r_volume_max   <= RST_VOLUME_MAX;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_TRACK_TOTAL:  r_track_total  <= i_cfg_data[7:0];
                REG_STABLE_TICKS: r_stable_ticks <= i_cfg_data[THR_W-1:0];
                REG_IGNORE_TICKS: r_ignore_ticks <= i_cfg_data[THR_W-1:0];
                REG_VOLUME_MAX:   r_volume_max   <= i_cfg_data[4:0];
                default: begin
                end
            endcase
        end
    end

    // Advance the controller state on each accepted event
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_volume      <= RST_VOLUME;
            r_track       <= RST_TRACK;
            r_playing     <= 1'b0;
            r_source      <= 1'b0;
            r_busy_stable <= 1'b1;
            r_busy_sample <= 1'b1;
            r_since_cmd   <= '0;
            r_since_chg   <= '0;
        end else if (in_beat) begin
            r_volume      <= n_volume;
            r_track       <= n_track;
            r_playing     <= n_playing;
            r_source      <= n_source;
            r_busy_stable <= n_busy_stable;
            r_busy_sample <= n_busy_sample;
            r_since_cmd   <= n_since_cmd;
            r_since_chg   <= n_since_chg;
        end
    end

    // Output buffer: result register in front, skid register behind it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (r_skid_valid) begin
                // drain the skid beat once the front one is taken
                if (out_beat) begin
                    r_skid_valid <= 1'b0;
                end
            end else if (in_beat && r_out_valid && !out_beat) begin
                r_skid_valid <= 1'b1;
            end
            if (!r_out_valid || out_beat) begin
                r_out_valid <= r_skid_valid || in_beat;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_beat) begin
                r_out <= r_skid;
            end
        end else if (in_beat) begin
            if (!r_out_valid || out_beat) begin
                r_out <= n_item;
            end else begin
                r_skid <= n_item;
            end
        end
    end

    // Skid slot only fills behind a waiting result
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid beat held without a front beat");

    // A stalled front beat is not overwritten
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> (r_out_valid && $stable(r_out)))
        else $error("waiting result changed");

    // Track number stays 1 based
    a_track_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.track_number != 8'd0))
        else $error("track number zero");

    // Play and previous-track commands leave playback on
    a_play_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.player_cmd == CMD_PLAY || r_out.player_cmd == CMD_PREV))
        |-> r_out.is_playing)
        else $error("play command without play flag");

endmodule
